[sv/rlfe_pkg.sv]
// Package for the RGB LED fade engine.
// Holds the default sizes, function codes, sequencer states and shared unit modes.
// No dependencies.
package rlfe_pkg;

  localparam int NUM_LEDS_DEF        = 24;
  localparam int FADE_STEPS_LOG2_DEF = 4;
  localparam int NUM_CH              = 3;

  typedef enum logic [1:0] {
    FUNC_SET   = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_SHIFT = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_WRITE
  } state_t;

  typedef enum logic [1:0] {
    ALU_PLAN,
    ALU_STEP,
    ALU_SNAP
  } alu_mode_t;

  typedef struct packed {
    logic cur_we;
    logic tgt_we;
    logic fade_we;
  } ram_wr_t;

  localparam logic [1:0] CH_LAST = 2'(NUM_CH - 1);

endpackage

[sv/rlfe_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rlfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/rlfe_chan_alu.sv]
// Shared per-channel arithmetic unit: plans a fade increment, takes one
// fractional fade step, or snaps to the target. Depends on rlfe_pkg.
module rlfe_chan_alu import rlfe_pkg::*; #(
  parameter int FADE_STEPS_LOG2 = FADE_STEPS_LOG2_DEF
) (
  input  alu_mode_t                    mode,
  input  logic [7:0]                   now,
  input  logic [7:0]                   goal,
  input  logic [16-FADE_STEPS_LOG2-1:0] inc_in,
  input  logic [7:0]                   frac_in,
  output logic [7:0]                   cur_out,
  output logic [16-FADE_STEPS_LOG2-1:0] inc_out,
  output logic [7:0]                   frac_out
);

  localparam int IW = 16 - FADE_STEPS_LOG2;

  logic          up;
  logic [7:0]    span;
  logic [15:0]   scaled;
  logic [IW-1:0] inc_plan;
  logic [15:0]   sum;
  logic [7:0]    whole;

  always_comb begin
    up     = goal > now;
    span   = up ? (goal - now) : (now - goal);
    scaled = {span, 8'h00} >> FADE_STEPS_LOG2;
    // The direction rides in the lowest bit: odd for up, even for down.
    inc_plan = scaled[IW-1:0];
    if (up != inc_plan[0]) begin
      inc_plan = inc_plan - IW'(1);
    end
    sum   = 16'(frac_in) + 16'(inc_in);
    whole = sum[15:8];
  end

  always_comb begin
    unique case (mode)
      ALU_PLAN: begin
        cur_out  = now;
        inc_out  = inc_plan;
        frac_out = 8'h00;
      end
      ALU_STEP: begin
        cur_out  = inc_in[0] ? (now + whole) : (now - whole);
        inc_out  = inc_in;
        frac_out = sum[7:0];
      end
      default: begin
        cur_out  = goal;
        inc_out  = inc_in;
        frac_out = frac_in;
      end
    endcase
  end

endmodule

[sv/rgb_led_fade_engine_unit.sv]
// Top level of the RGB LED fade engine: sequencer, per-LED state memories
// and output register. Depends on rlfe_pkg, rlfe_ram and rlfe_chan_alu.
//
//   Channel  Ports                                          Direction  Handshake
//   input    in_func, in_led_index, in_green/red/blue       in         in_valid / in_stall
//   result   out_led_position, out_green/red/blue, out_last out        out_valid / out_stall
//
// Each LED is handled in turn: its memory row is loaded, the shared channel
// unit works on each colour channel in turn and the row is written back.
// A tick and a set-all visit every LED, a single set one and a shift all but
// the lowest; a tick also waits while the result side stalls.
// After reset a clearing pass zeroes the memories, one row after another; no item
// is taken meanwhile. A stalled result holds in the output register while the
// next LED's row is loaded; the sequencer waits only to emit the next colour.
module rgb_led_fade_engine_unit import rlfe_pkg::*; #(
  parameter int NUM_LEDS        = NUM_LEDS_DEF,
  parameter int FADE_STEPS_LOG2 = FADE_STEPS_LOG2_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [4:0] in_led_index,
  input  logic [7:0] in_green,
  input  logic [7:0] in_red,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_led_position,
  output logic [7:0] out_green,
  output logic [7:0] out_red,
  output logic [7:0] out_blue,
  output logic       out_last
);

  localparam int LW = $clog2(NUM_LEDS);
  localparam int IW = 16 - FADE_STEPS_LOG2;
  localparam int SW = FADE_STEPS_LOG2 + 1;
  localparam int FW = SW + 3 * IW + 24;
  localparam logic [LW-1:0] LED_LAST   = LW'(NUM_LEDS - 1);
  localparam logic [8:0]    LED_TOTAL  = 9'(NUM_LEDS);
  localparam logic [SW-1:0] STEPS_FULL = {1'b1, {FADE_STEPS_LOG2{1'b0}}};

  state_t  state_r, state_nxt;
  logic [LW-1:0] led_r, led_nxt;
  logic [1:0]    ch_r, ch_nxt;
  logic          out_valid_r, out_valid_nxt;

  func_t                 func_r, func_nxt;
  logic                  all_r;
  logic [2:0][7:0]       goal_r;
  logic [2:0][7:0]       cur_r;
  logic [2:0][IW-1:0]    inc_r;
  logic [2:0][7:0]       frac_r;
  logic [SW-1:0]         steps_r;

  logic [8:0]    idx_m1;
  logic          load_go;
  logic          seq_done;
  logic [LW-1:0] tgt_raddr;
  logic [8:0]    led_wide;

  ram_wr_t       wr;
  alu_mode_t     alu_mode;
  logic [23:0]   cur_wdata, tgt_wdata;
  logic [FW-1:0] fade_wdata;
  logic [SW-1:0] steps_wr;
  logic [23:0]   cur_rdata, tgt_rdata;
  logic [FW-1:0] fade_rdata;

  logic [7:0]    alu_cur;
  logic [IW-1:0] alu_inc;
  logic [7:0]    alu_frac;

  assign idx_m1   = {4'b0, in_led_index} - 9'd1;
  assign load_go  = (state_r == ST_LOAD) &&
                    !(func_r == FUNC_TICK && out_valid_r && out_stall);
  assign seq_done = (func_r == FUNC_SET && !all_r) ||
                    (func_r == FUNC_SHIFT && led_r == LW'(1)) ||
                    (func_r != FUNC_SHIFT && led_r == LED_LAST);
  assign func_nxt = (state_r == ST_IDLE) ? func_t'(in_func) : func_r;
  // A shift takes its new target from the LED below.
  assign tgt_raddr = (func_nxt == FUNC_SHIFT) ? (led_nxt - LW'(1)) : led_nxt;
  assign led_wide  = 9'(led_r);

  // Next state and counters.
  always_comb begin
    state_nxt = state_r;
    led_nxt   = led_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      ST_CLEAR: begin
        led_nxt = led_r + LW'(1);
        if (led_r == LED_LAST) begin
          state_nxt = ST_IDLE;
          led_nxt   = '0;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (func_t'(in_func))
            FUNC_SET: begin
              if (in_led_index == 5'd0) begin
                led_nxt   = '0;
                state_nxt = ST_LOAD;
              end else if ({4'b0, in_led_index} <= LED_TOTAL) begin
                led_nxt   = idx_m1[LW-1:0];
                state_nxt = ST_LOAD;
              end
            end
            FUNC_TICK: begin
              led_nxt   = '0;
              state_nxt = ST_LOAD;
            end
            FUNC_SHIFT: begin
              led_nxt   = LED_LAST;
              state_nxt = ST_LOAD;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_LOAD: begin
        if (load_go) begin
          state_nxt = ST_CALC;
          ch_nxt    = 2'd0;
        end
      end
      ST_CALC: begin
        if (ch_r == CH_LAST) begin
          state_nxt = ST_WRITE;
        end else begin
          ch_nxt = ch_r + 2'd1;
        end
      end
      ST_WRITE: begin
        if (seq_done) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_LOAD;
          led_nxt   = (func_r == FUNC_SHIFT) ? (led_r - LW'(1)) : (led_r + LW'(1));
        end
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    if (func_r == FUNC_TICK) begin
      alu_mode = (steps_r == '0) ? ALU_SNAP : ALU_STEP;
    end else begin
      alu_mode = ALU_PLAN;
    end
    wr.cur_we  = (state_r == ST_CLEAR) || (state_r == ST_WRITE && func_r == FUNC_TICK);
    wr.tgt_we  = (state_r == ST_CLEAR) || (state_r == ST_WRITE && func_r != FUNC_TICK);
    wr.fade_we = (state_r == ST_CLEAR) || (state_r == ST_WRITE);
    if (func_r == FUNC_TICK) begin
      steps_wr = (steps_r == '0) ? '0 : (steps_r - SW'(1));
    end else begin
      steps_wr = STEPS_FULL;
    end
    if (state_r == ST_CLEAR) begin
      cur_wdata  = '0;
      tgt_wdata  = '0;
      fade_wdata = '0;
    end else begin
      cur_wdata  = cur_r;
      tgt_wdata  = goal_r;
      fade_wdata = {steps_wr, inc_r, frac_r};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_go && func_r == FUNC_TICK) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      led_r       <= '0;
      ch_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      led_r       <= led_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      func_r <= func_t'(in_func);
      all_r  <= (in_led_index == 5'd0);
      goal_r <= {in_blue, in_red, in_green};
    end
    if (load_go) begin
      cur_r                     <= cur_rdata;
      {steps_r, inc_r, frac_r}  <= fade_rdata;
      if (func_r != FUNC_SET) begin
        goal_r <= tgt_rdata;
      end
      if (func_r == FUNC_TICK) begin
        out_led_position <= led_wide[4:0];
        out_green        <= cur_rdata[7:0];
        out_red          <= cur_rdata[15:8];
        out_blue         <= cur_rdata[23:16];
        out_last         <= (led_r == LED_LAST);
      end
    end
    if (state_r == ST_CALC) begin
      cur_r[ch_r]  <= alu_cur;
      inc_r[ch_r]  <= alu_inc;
      frac_r[ch_r] <= alu_frac;
    end
  end

  assign out_valid = out_valid_r;

  rlfe_chan_alu #(
    .FADE_STEPS_LOG2(FADE_STEPS_LOG2)
  ) u_alu (
    .mode    (alu_mode),
    .now     (cur_r[ch_r]),
    .goal    (goal_r[ch_r]),
    .inc_in  (inc_r[ch_r]),
    .frac_in (frac_r[ch_r]),
    .cur_out (alu_cur),
    .inc_out (alu_inc),
    .frac_out(alu_frac)
  );

  rlfe_ram #(
    .WIDTH(24),
    .DEPTH(NUM_LEDS)
  ) u_cur_ram (
    .clk  (clk),
    .we   (wr.cur_we),
    .waddr(led_r),
    .wdata(cur_wdata),
    .raddr(led_nxt),
    .rdata(cur_rdata)
  );

  rlfe_ram #(
    .WIDTH(24),
    .DEPTH(NUM_LEDS)
  ) u_tgt_ram (
    .clk  (clk),
    .we   (wr.tgt_we),
    .waddr(led_r),
    .wdata(tgt_wdata),
    .raddr(tgt_raddr),
    .rdata(tgt_rdata)
  );

  rlfe_ram #(
    .WIDTH(FW),
    .DEPTH(NUM_LEDS)
  ) u_fade_ram (
    .clk  (clk),
    .we   (wr.fade_we),
    .waddr(led_r),
    .wdata(fade_wdata),
    .raddr(led_nxt),
    .rdata(fade_rdata)
  );

endmodule

[bench/tb_rgb_led_fade_engine_unit.sv]
// Self-checking testbench for rgb_led_fade_engine_unit: directed and random commands,
// a predictor of the LED fade state and a per-field check of every emitted colour.
// Depends on rlfe_pkg and the RTL of the fade engine.
module tb_rgb_led_fade_engine_unit import rlfe_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LEDS     = NUM_LEDS_DEF;
  localparam int STEPS_LOG2   = FADE_STEPS_LOG2_DEF;
  localparam int WANTED_CMDS  = 450;
  localparam int SETTLE_WAIT  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 300;

  typedef struct {
    func_t      func;
    logic [4:0] idx;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    int         gap;
    bit         drain;
  } led_cmd_t;

  typedef struct {
    logic [4:0] pos;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic       last;
  } led_frame_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_func = FUNC_NOP;
  logic [4:0] in_led_index = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_red = '0;
  logic [7:0] in_blue = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [4:0] out_led_position;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [7:0] out_blue;
  logic       out_last;

  rgb_led_fade_engine_unit #(
    .NUM_LEDS       (NUM_LEDS),
    .FADE_STEPS_LOG2(STEPS_LOG2)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_led_index    (in_led_index),
    .in_green        (in_green),
    .in_red          (in_red),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_led_position(out_led_position),
    .out_green       (out_green),
    .out_red         (out_red),
    .out_blue        (out_blue),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fade state as the block should hold it; channel 0 is green, 1 red, 2 blue.
  logic [7:0]  cur_lvl   [NUM_LEDS][NUM_CH];
  logic [7:0]  tgt_lvl   [NUM_LEDS][NUM_CH];
  int          fade_left [NUM_LEDS];
  logic [15:0] step_inc  [NUM_LEDS][NUM_CH];
  logic [7:0]  step_frac [NUM_LEDS][NUM_CH];

  led_cmd_t   cmd_q[$];
  led_frame_t pending_frames[$];
  int         cmds_total;
  int         cmds_sent;
  int         useful_cmds;
  int         fails;
  int         frames_seen;
  bit         snd_calm;
  bit         rcv_calm;

  task automatic plan_channel(input int led, input int ch, input logic [7:0] goal);
    logic [7:0]  now;
    logic        up;
    logic [15:0] span;
    logic [15:0] inc;
    now  = cur_lvl[led][ch];
    up   = goal > now;
    span = up ? 16'(goal - now) : 16'(now - goal);
    inc  = (span << 8) >> STEPS_LOG2;
    // The direction rides in the lowest bit: odd for up, even for down.
    if (up != inc[0])
      inc = inc - 16'd1;
    step_inc[led][ch]  = inc;
    step_frac[led][ch] = '0;
  endtask

  task automatic aim_led(input int led, input logic [7:0] g, input logic [7:0] r,
                         input logic [7:0] b);
    fade_left[led]    = 1 << STEPS_LOG2;
    tgt_lvl[led][0]   = g;
    tgt_lvl[led][1]   = r;
    tgt_lvl[led][2]   = b;
    plan_channel(led, 0, g);
    plan_channel(led, 1, r);
    plan_channel(led, 2, b);
  endtask

  task automatic predict_led_frames(input led_cmd_t c);
    led_frame_t  f;
    logic [16:0] sum;
    case (c.func)
      FUNC_SET: begin
        for (int led = 0; led < NUM_LEDS; led++)
          if (c.idx == 0 || c.idx == led + 1)
            aim_led(led, c.green, c.red, c.blue);
      end
      FUNC_TICK: begin
        for (int led = 0; led < NUM_LEDS; led++) begin
          f.pos   = 5'(led);
          f.green = cur_lvl[led][0];
          f.red   = cur_lvl[led][1];
          f.blue  = cur_lvl[led][2];
          f.last  = (led == NUM_LEDS - 1);
          pending_frames.push_back(f);
        end
        for (int led = 0; led < NUM_LEDS; led++) begin
          if (fade_left[led] == 0) begin
            for (int ch = 0; ch < NUM_CH; ch++)
              cur_lvl[led][ch] = tgt_lvl[led][ch];
          end else begin
            fade_left[led]--;
            for (int ch = 0; ch < NUM_CH; ch++) begin
              sum = 17'(step_frac[led][ch]) + 17'(step_inc[led][ch]);
              if (step_inc[led][ch][0])
                cur_lvl[led][ch] = cur_lvl[led][ch] + sum[15:8];
              else
                cur_lvl[led][ch] = cur_lvl[led][ch] - sum[15:8];
              step_frac[led][ch] = sum[7:0];
            end
          end
        end
      end
      FUNC_SHIFT: begin
        for (int led = NUM_LEDS - 1; led >= 1; led--)
          aim_led(led, tgt_lvl[led-1][0], tgt_lvl[led-1][1], tgt_lvl[led-1][2]);
      end
      default: ;
    endcase
  endtask

  task automatic add_cmd(input func_t func, input int idx, input logic [7:0] g,
                         input logic [7:0] r, input logic [7:0] b, input bit drain);
    led_cmd_t c;
    if ($urandom_range(0, 24) == 0)
      snd_calm = !snd_calm;
    c.func  = func;
    c.idx   = 5'(idx);
    c.green = g;
    c.red   = r;
    c.blue  = b;
    c.gap   = snd_calm ? 0 : $urandom_range(0, 13);
    c.drain = drain;
    cmd_q.push_back(c);
    if (func != FUNC_NOP && !(func == FUNC_SET && idx > NUM_LEDS))
      useful_cmds++;
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sender: holds a stalled command, then waits out the gap of the next one.
  led_cmd_t cur_cmd;
  led_cmd_t nxt_cmd;
  bit       have_nxt;
  int       gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      have_nxt  = 1'b0;
      gap_left  = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_led_frames(cur_cmd);
        cmds_sent++;
      end
      if (!have_nxt && cmd_q.size() != 0) begin
        nxt_cmd  = cmd_q.pop_front();
        have_nxt = 1'b1;
        gap_left = nxt_cmd.gap;
      end
      if (have_nxt && gap_left == 0 && !(nxt_cmd.drain && pending_frames.size() != 0)) begin
        cur_cmd       = nxt_cmd;
        have_nxt      = 1'b0;
        in_valid     <= 1'b1;
        in_func      <= nxt_cmd.func;
        in_led_index <= nxt_cmd.idx;
        in_green     <= nxt_cmd.green;
        in_red       <= nxt_cmd.red;
        in_blue      <= nxt_cmd.blue;
      end else begin
        in_valid <= 1'b0;
        if (have_nxt && gap_left > 0)
          gap_left--;
      end
    end
  end

  // Receiver: checks each transfer against the oldest expected frame.
  int         stall_left;
  int         hold_left;
  led_frame_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        frames_seen++;
        if (pending_frames.size() == 0) begin
          $error("unexpected colour for LED position %0d", out_led_position);
          fails++;
        end else begin
          want = pending_frames.pop_front();
          if (out_led_position !== want.pos) begin
            $error("out_led_position: expected %0d, got %0d", want.pos, out_led_position);
            fails++;
          end
          if (out_green !== want.green) begin
            $error("out_green: expected %0d, got %0d", want.green, out_green);
            fails++;
          end
          if (out_red !== want.red) begin
            $error("out_red: expected %0d, got %0d", want.red, out_red);
            fails++;
          end
          if (out_blue !== want.blue) begin
            $error("out_blue: expected %0d, got %0d", want.blue, out_blue);
            fails++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, out_last);
            fails++;
          end
        end
        if ($urandom_range(0, 24) == 0)
          rcv_calm = !rcv_calm;
        stall_left = rcv_calm ? 0 : $urandom_range(0, 13);
        // A long hold-off lets the block back up into its input.
        if (frames_seen == 150 || frames_seen == 3000)
          hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  int idle_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int run;
    for (int led = 0; led < NUM_LEDS; led++) begin
      fade_left[led] = 0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        cur_lvl[led][ch]   = '0;
        tgt_lvl[led][ch]   = '0;
        step_inc[led][ch]  = '0;
        step_frac[led][ch] = '0;
      end
    end
    fails       = 0;
    cmds_sent   = 0;
    useful_cmds = 0;
    frames_seen = 0;
    snd_calm    = 1'b0;
    rcv_calm    = 1'b0;

    // Directed: all-off tick, set-all to full, single LEDs at both ends,
    // out-of-range LED numbers, the unused code, shifts and fades both ways.
    add_cmd(FUNC_TICK,  0,  8'h00, 8'h00, 8'h00, 1'b0);
    add_cmd(FUNC_SET,   0,  8'hFF, 8'hFF, 8'hFF, 1'b1);
    add_cmd(FUNC_TICK,  0,  8'h00, 8'h00, 8'h00, 1'b0);
    add_cmd(FUNC_TICK,  0,  8'h00, 8'h00, 8'h00, 1'b0);
    add_cmd(FUNC_SET,   NUM_LEDS, 8'h00, 8'h00, 8'h00, 1'b0);
    add_cmd(FUNC_SET,   1,  8'h80, 8'h01, 8'hFE, 1'b0);
    add_cmd(FUNC_SET,   NUM_LEDS + 1, 8'h12, 8'h34, 8'h56, 1'b0);
    add_cmd(FUNC_SET,   31, 8'hFF, 8'h00, 8'hFF, 1'b0);
    add_cmd(FUNC_NOP,   16, 8'hAA, 8'h55, 8'hFF, 1'b0);
    add_cmd(FUNC_SHIFT, 0,  8'h00, 8'h00, 8'h00, 1'b0);
    add_cmd(FUNC_TICK,  0,  8'h00, 8'h00, 8'h00, 1'b0);
    add_cmd(FUNC_SET,   0,  8'h00, 8'h00, 8'h00, 1'b0);
    add_cmd(FUNC_TICK,  0,  8'h00, 8'h00, 8'h00, 1'b0);
    add_cmd(FUNC_SET,   12, 8'hFF, 8'h00, 8'hFF, 1'b0);
    add_cmd(FUNC_TICK,  0,  8'h00, 8'h00, 8'h00, 1'b0);
    add_cmd(FUNC_TICK,  0,  8'h00, 8'h00, 8'h00, 1'b0);
    add_cmd(FUNC_SHIFT, 0,  8'h00, 8'h00, 8'h00, 1'b0);
    add_cmd(FUNC_TICK,  0,  8'h00, 8'h00, 8'h00, 1'b0);

    // Random: mostly fade runs (targets, maybe a shift, then enough ticks to
    // finish or interrupt the fade), the rest any code with any LED number.
    run = 0;
    useful_cmds = 0;
    while (useful_cmds < WANTED_CMDS) begin
      if ($urandom_range(0, 9) < 6) begin
        run++;
        repeat ($urandom_range(1, 3))
          add_cmd(FUNC_SET, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, NUM_LEDS),
                  pick_level(), pick_level(), pick_level(), run % 8 == 0);
        if ($urandom_range(0, 4) == 0)
          add_cmd(FUNC_SHIFT, 0, 8'h00, 8'h00, 8'h00, 1'b0);
        repeat ($urandom_range(2, 19))
          add_cmd(FUNC_TICK, $urandom_range(0, 31), pick_level(), pick_level(),
                  pick_level(), 1'b0);
      end else begin
        add_cmd(func_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'b0);
      end
    end
    cmds_total = cmd_q.size() + 0;
    cmds_total = 0;
    foreach (cmd_q[i])
      cmds_total++;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do
      @(posedge clk);
    while (cmds_sent != cmds_total || pending_frames.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk);

    if (fails == 0 && pending_frames.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
